>>> hdl/bcc_pkg.sv
package bcc_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned LIMIT_W     = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_HOLD  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_GAP = CFG_INDEX_W'(1);

  localparam logic [LIMIT_W-1:0] LONG_HOLD_RESET  = 8'd200;
  localparam logic [LIMIT_W-1:0] DOUBLE_GAP_RESET = 8'd30;
  localparam logic [LIMIT_W-1:0] COUNT_MAX        = 8'hFF;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

endpackage

>>> hdl/button_click_classifier_core.sv
// Output: the event for a sample appears on the master side in the cycle after the
// sample's transaction, held in the output register until taken.
// Throughput: one sample per cycle unless an event waits untaken; the output
// register accepts a new sample in the same cycle that the prior event is taken.
// Reset: synchronous rst clears the debounce and double-click state, empties the
// output register and restores the limits to 200 and 30 ticks.
module button_click_classifier_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [0] pressed, [7:1] zero
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // [1:0] event_res, [7:2] zero
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bcc_pkg::LIMIT_W-1:0]      cfg_data
);
  import bcc_pkg::*;

  logic [LIMIT_W-1:0] long_hold_ticks;
  logic [LIMIT_W-1:0] double_gap_ticks;
  logic               awaiting_second;
  logic               awaiting_second_next;
  logic [LIMIT_W-1:0] gap_count;
  logic [LIMIT_W-1:0] gap_count_next;
  logic [LIMIT_W-1:0] gap_inc;
  event_t             ev;
  event_t             res;
  event_t             res_q;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {6'd0, res_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      long_hold_ticks  <= LONG_HOLD_RESET;
      double_gap_ticks <= DOUBLE_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LONG_HOLD) long_hold_ticks <= cfg_data;
      if (cfg_index == CFG_DOUBLE_GAP) double_gap_ticks <= cfg_data;
    end
  end

  bcc_debounce u_debounce (
    .clk             (clk),
    .rst             (rst),
    .step            (accept),
    .down            (s_tdata[0]),
    .long_hold_ticks (long_hold_ticks),
    .ev              (ev)
  );

  assign gap_inc = (gap_count == COUNT_MAX) ? gap_count : gap_count + LIMIT_W'(1);

  always_comb begin
    awaiting_second_next = awaiting_second;
    gap_count_next       = gap_count;
    res                  = EV_NONE;
    if (!awaiting_second) begin
      if (ev == EV_SHORT) begin
        gap_count_next       = '0;
        awaiting_second_next = 1'b1;
      end else begin
        res = ev;
      end
    end else if (ev == EV_SHORT) begin
      res                  = EV_DOUBLE;
      awaiting_second_next = 1'b0;
    end else begin
      gap_count_next = gap_inc;
      if (gap_inc >= double_gap_ticks) begin
        res                  = EV_SHORT;
        awaiting_second_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_second <= 1'b0;
      gap_count       <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (accept) begin
        awaiting_second <= awaiting_second_next;
        gap_count       <= gap_count_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_q <= res;
  end

  a_double_after_second_short: assert property (@(posedge clk) disable iff (rst)
    (accept && awaiting_second && ev == EV_SHORT) |=> (m_tvalid && res_q == EV_DOUBLE))
    else $error("second short inside the window did not give a double event");

  a_first_short_held: assert property (@(posedge clk) disable iff (rst)
    (accept && !awaiting_second && ev == EV_SHORT) |=> (awaiting_second && res_q == EV_NONE))
    else $error("first short was not held back");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while the output register could take a transaction");

endmodule

>>> hdl/bcc_debounce.sv
module bcc_debounce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         down,
  input  logic [bcc_pkg::LIMIT_W-1:0]  long_hold_ticks,
  output bcc_pkg::event_t              ev
);
  import bcc_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic [LIMIT_W-1:0]   hold_count;
  logic [LIMIT_W-1:0]   hold_count_next;
  logic [LIMIT_W-1:0]   hold_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hold_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      hold_count <= hold_count_next;
    end
  end

  assign hold_inc = (hold_count == COUNT_MAX) ? hold_count : hold_count + LIMIT_W'(1);

  always_comb begin
    phase_next      = phase;
    hold_count_next = hold_count;
    ev              = EV_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (down) phase_next = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (down) begin
          hold_count_next = '0;
          phase_next      = PH_HOLD;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (!down) begin
          ev         = EV_SHORT;
          phase_next = PH_IDLE;
        end else begin
          hold_count_next = hold_inc;
          if (hold_inc >= long_hold_ticks) begin
            ev         = EV_LONG;
            phase_next = PH_RELEASE;
          end
        end
      end
      PH_RELEASE: begin
        if (!down) phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

endmodule
